@@ hw/rtl/spm_pkg.sv @@
// Package for the slotted page manager: sizes, opcodes and status codes.
// No dependencies.
package spm_pkg;
   localparam int PageBytesDef   = 8192;
   localparam int HeaderBytesDef = 24;
   localparam int SlotBytesDef   = 8;
   localparam int MaxSlotsDef    = 512;

   localparam logic [2:0] OP_INIT    = 3'd0;
   localparam logic [2:0] OP_ADD     = 3'd1;
   localparam logic [2:0] OP_DELETE  = 3'd2;
   localparam logic [2:0] OP_COMPACT = 3'd3;
   localparam logic [2:0] OP_CHECK   = 3'd4;
   localparam logic [2:0] OP_READ    = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_BAD_SLOT = 2'd2;
   localparam logic [1:0] ST_NOT_LIVE = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic        live;
      logic [13:0] item_length;
      logic [7:0]  read_byte;
   } rsp_info_type;
endpackage

@@ hw/rtl/spm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module spm_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ hw/rtl/slotted_page_manager_core.sv @@
// Top level of the slotted page manager: sequencer around the page, scratch and slot memories.
// Depends on spm_pkg and spm_ram.
//
//  channel | direction | handshake        | contents
//  req     | in        | req_valid/stall  | opcode, slot, size, index, byte, last
//  rsp     | out       | rsp_valid/stall  | status, free space, slots in use, live, length, byte
//
// Check, delete and refused reads take a directory read and an execute step, then the result;
// add beats and byte reads add a byte step, and unknown opcodes go straight to the result.
// Init and reset sweep the slot directory and the page, one entry a cycle.
// Compact reads each slot entry and copies the bytes of live items through the scratch page, then
// clears the unused directory entries and writes the whole page back.
// Requests are stalled in the reset sweep, during each operation and whilst a result waits.
module slotted_page_manager_core
   import spm_pkg::*;
#(
   parameter int PageBytes   = PageBytesDef,
   parameter int HeaderBytes = HeaderBytesDef,
   parameter int SlotBytes   = SlotBytesDef,
   parameter int MaxSlots    = MaxSlotsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [9:0]  req_slot_number,
   input  logic [13:0] req_item_size,
   input  logic [12:0] req_byte_index,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [13:0] rsp_free_space,
   output logic [9:0]  rsp_slots_in_use,
   output logic        rsp_live,
   output logic [13:0] rsp_item_length,
   output logic [7:0]  rsp_read_byte
);
   localparam int PAW = $clog2(PageBytes);
   localparam int SAW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
   localparam int SD  = (MaxSlots > 1) ? MaxSlots : 2;
   localparam int VW  = PAW + 2;
   localparam int ClearLast = ((PageBytes > MaxSlots) ? PageBytes : MaxSlots) - 1;
   localparam logic [VW-1:0] PAGE_V = VW'(PageBytes);

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_EXEC = 4'd3,
      S_BYTE = 4'd4, S_RSP = 4'd5, S_C_RD = 4'd6, S_C_EX = 4'd7, S_C_CP = 4'd8,
      S_C_ZERO = 4'd9, S_C_BACK = 4'd10, S_C_BK2 = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [9:0]    slot_ff, slot_in;
   logic [13:0]   size_ff, size_in;
   logic [12:0]   bidx_ff, bidx_in;
   logic [7:0]    dbyte_ff, dbyte_in;
   logic          last_ff, last_in;
   logic [10:0]   used_ff, used_in;
   logic [VW-1:0] top_ff, top_in;
   logic          busy_ff, busy_in;
   logic [1:0]    astat_ff, astat_in;
   logic [13:0]   alen_ff, alen_in;
   logic [13:0]   prog_ff, prog_in;
   logic [VW-1:0] aoff_ff, aoff_in;
   rsp_info_type  info_ff, info_in;
   logic [13:0]   idx_ff, idx_in;
   logic [10:0]   n_ff, n_in;
   logic [VW-1:0] coff_ff, coff_in;
   logic [VW-1:0] clen_ff, clen_in;
   logic [VW-1:0] cnt_ff, cnt_in;

   logic           sw_en;
   logic [SAW-1:0] sw_addr, sr_addr;
   logic [27:0]    sw_data, sr_data;
   logic           pw_en, xw_en;
   logic [PAW-1:0] pw_addr, pr_addr, xw_addr, xr_addr;
   logic [7:0]     pw_data, pr_data, xw_data, xr_data;

   spm_ram #(.Width(28), .Depth(SD)) u_slots (
      .clock, .wr_en(sw_en), .wr_addr(sw_addr), .wr_data(sw_data),
      .rd_addr(sr_addr), .rd_data(sr_data));
   spm_ram #(.Width(8), .Depth(PageBytes)) u_page (
      .clock, .wr_en(pw_en), .wr_addr(pw_addr), .wr_data(pw_data),
      .rd_addr(pr_addr), .rd_data(pr_data));
   spm_ram #(.Width(8), .Depth(PageBytes)) u_scratch (
      .clock, .wr_en(xw_en), .wr_addr(xw_addr), .wr_data(xw_data),
      .rd_addr(xr_addr), .rd_data(xr_data));

   logic [VW+11:0] low_w;
   logic [VW-1:0]  free_w;
   logic [VW-1:0]  soff_w, slen_w;
   logic           valid_w;
   logic [VW+1:0]  ext_w;

   assign low_w  = (VW+12)'(HeaderBytes) + (VW+12)'(used_ff) * (VW+12)'(SlotBytes);
   assign free_w = ((VW+12)'(top_ff) > low_w) ? VW'((VW+12)'(top_ff) - low_w) : '0;
   assign soff_w = VW'(sr_data[27:14]);
   assign slen_w = VW'(sr_data[13:0]);
   assign valid_w = slot_ff >= 10'd1 && 11'(slot_ff) <= used_ff
                    && 32'(slot_ff) <= MaxSlots;
   assign ext_w = (VW+2)'(soff_w) + (VW+2)'(bidx_ff);

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RSP;
   assign rsp_status = info_ff.status;
   assign rsp_live = info_ff.live;
   assign rsp_item_length = info_ff.item_length;
   assign rsp_read_byte = info_ff.read_byte;
   assign rsp_free_space = 14'(free_w);
   assign rsp_slots_in_use = 10'(used_ff);

   always_comb begin
      state_in = state_ff; op_in = op_ff; slot_in = slot_ff; size_in = size_ff;
      bidx_in = bidx_ff; dbyte_in = dbyte_ff; last_in = last_ff; used_in = used_ff;
      top_in = top_ff; busy_in = busy_ff; astat_in = astat_ff;
      alen_in = alen_ff; prog_in = prog_ff; aoff_in = aoff_ff; info_in = info_ff;
      idx_in = idx_ff; n_in = n_ff; coff_in = coff_ff; clen_in = clen_ff; cnt_in = cnt_ff;
      sw_en = 1'b0; sw_addr = '0; sw_data = '0; sr_addr = '0;
      pw_en = 1'b0; pw_addr = '0; pw_data = '0; pr_addr = '0;
      xw_en = 1'b0; xw_addr = '0; xw_data = '0; xr_addr = '0;
      unique case (state_ff)
         S_CLEAR: begin
            sw_en = 32'(idx_ff) < MaxSlots; sw_addr = SAW'(idx_ff);
            pw_en = 32'(idx_ff) < PageBytes; pw_addr = PAW'(idx_ff);
            if (32'(idx_ff) == ClearLast) begin
               state_in = (op_ff == OP_INIT) ? S_RSP : S_IDLE;
            end
            idx_in = idx_ff + 14'd1;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode; slot_in = req_slot_number; size_in = req_item_size;
               bidx_in = req_byte_index; dbyte_in = req_data_byte; last_in = req_last_byte;
               info_in = '0;
               if (req_opcode != OP_ADD) begin
                  busy_in = 1'b0; prog_in = '0; astat_in = ST_OK;
               end
               sr_addr = SAW'(req_slot_number - 10'd1);
               unique case (req_opcode)
                  OP_INIT: begin
                     used_in = '0; top_in = PAGE_V; idx_in = '0; state_in = S_CLEAR;
                  end
                  OP_COMPACT: begin
                     idx_in = '0; n_in = '0; top_in = PAGE_V; state_in = S_C_RD;
                  end
                  OP_ADD, OP_DELETE, OP_CHECK, OP_READ: state_in = S_RD;
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_RD: begin
            sr_addr = SAW'(slot_ff - 10'd1);
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RSP;
            unique case (op_ff)
               OP_ADD: begin
                  if (!busy_ff) begin
                     busy_in = 1'b1; prog_in = '0; alen_in = size_ff;
                     if (slot_ff < 10'd1 || 11'(slot_ff) > used_ff + 11'd1
                         || 32'(slot_ff) > MaxSlots) begin
                        astat_in = ST_BAD_SLOT;
                     end else if (32'(free_w) <= 32'(size_ff) + SlotBytes) begin
                        astat_in = ST_NO_SPACE;
                     end else begin
                        astat_in = ST_OK;
                        top_in = top_ff - VW'(size_ff);
                        aoff_in = top_ff - VW'(size_ff);
                        sw_en = 1'b1; sw_addr = SAW'(slot_ff - 10'd1);
                        sw_data = {14'(top_ff - VW'(size_ff)), size_ff};
                        if (11'(slot_ff) > used_ff) used_in = used_ff + 11'd1;
                     end
                  end
                  state_in = S_BYTE;
               end
               OP_DELETE: begin
                  if (!valid_w) info_in.status = ST_BAD_SLOT;
                  else begin
                     sw_en = 1'b1; sw_addr = SAW'(slot_ff - 10'd1); sw_data = '0;
                  end
               end
               OP_CHECK: begin
                  if (!valid_w) info_in.status = ST_BAD_SLOT;
                  else begin
                     info_in.live = soff_w != '0; info_in.item_length = 14'(slen_w);
                  end
               end
               OP_READ: begin
                  pr_addr = PAW'(ext_w);
                  if (!valid_w) info_in.status = ST_BAD_SLOT;
                  else begin
                     info_in.live = soff_w != '0; info_in.item_length = 14'(slen_w);
                     if (soff_w == '0) info_in.status = ST_NOT_LIVE;
                     else if ((VW+2)'(bidx_ff) >= (VW+2)'(slen_w)
                              || ext_w >= (VW+2)'(PageBytes)) begin
                        info_in.status = ST_BAD_SLOT;
                     end else state_in = S_BYTE;
                  end
               end
               default: ;
            endcase
         end
         S_BYTE: begin
            state_in = S_RSP;
            if (op_ff == OP_READ) info_in.read_byte = pr_data;
            else begin
               info_in.status = astat_ff;
               if (astat_ff == ST_OK) begin
                  if (prog_ff < alen_ff) begin
                     if ((VW+1)'(aoff_ff) + (VW+1)'(prog_ff) < (VW+1)'(PageBytes)) begin
                        pw_en = 1'b1; pw_addr = PAW'(aoff_ff + VW'(prog_ff));
                        pw_data = dbyte_ff;
                     end
                     prog_in = prog_ff + 14'd1;
                  end
                  info_in.live = aoff_ff != '0; info_in.item_length = alen_ff;
               end
               if (last_ff) begin
                  busy_in = 1'b0; prog_in = '0; astat_in = ST_OK;
               end
            end
         end
         S_RSP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         S_C_RD: begin
            if (11'(idx_ff) >= used_ff || 32'(idx_ff) >= MaxSlots) begin
               idx_in = 14'(n_ff); state_in = S_C_ZERO;
            end else begin
               sr_addr = SAW'(idx_ff); state_in = S_C_EX;
            end
         end
         S_C_EX: begin
            idx_in = idx_ff + 14'd1;
            state_in = S_C_RD;
            if (soff_w != '0) begin
               clen_in = (slen_w > top_ff) ? '0 : slen_w;
               coff_in = soff_w;
               top_in = top_ff - ((slen_w > top_ff) ? '0 : slen_w);
               sw_en = 1'b1; sw_addr = SAW'(n_ff);
               sw_data = {14'(top_ff - ((slen_w > top_ff) ? '0 : slen_w)),
                          14'((slen_w > top_ff) ? '0 : slen_w)};
               n_in = n_ff + 11'd1;
               cnt_in = '0;
               pr_addr = PAW'(soff_w);
               if (slen_w != '0 && slen_w <= top_ff) state_in = S_C_CP;
            end
         end
         S_C_CP: begin
            xw_en = 1'b1; xw_addr = PAW'(top_ff + cnt_ff); xw_data = pr_data;
            cnt_in = cnt_ff + 1'b1;
            pr_addr = PAW'(coff_ff + cnt_ff + 1'b1);
            if (cnt_ff + 1'b1 == clen_ff) state_in = S_C_RD;
         end
         S_C_ZERO: begin
            if (32'(idx_ff) >= MaxSlots) begin
               used_in = n_ff; cnt_in = '0; state_in = S_C_BACK;
            end else begin
               sw_en = 1'b1; sw_addr = SAW'(idx_ff); idx_in = idx_ff + 14'd1;
            end
         end
         S_C_BACK: begin
            if (cnt_ff >= PAGE_V) state_in = S_RSP;
            else begin
               xr_addr = PAW'(cnt_ff); state_in = S_C_BK2;
            end
         end
         S_C_BK2: begin
            pw_en = 1'b1; pw_addr = PAW'(cnt_ff);
            pw_data = (cnt_ff < top_ff) ? 8'd0 : xr_data;
            cnt_in = cnt_ff + 1'b1;
            xr_addr = PAW'(cnt_ff + 1'b1);
            if (cnt_ff + 1'b1 >= PAGE_V) state_in = S_RSP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; op_ff <= OP_COMPACT; idx_ff <= '0; used_ff <= '0;
         top_ff <= PAGE_V; busy_ff <= 1'b0; astat_ff <= ST_OK; prog_ff <= '0;
      end else begin
         state_ff <= state_in; op_ff <= op_in; idx_ff <= idx_in; used_ff <= used_in;
         top_ff <= top_in; busy_ff <= busy_in; astat_ff <= astat_in; prog_ff <= prog_in;
      end
      slot_ff <= slot_in; size_ff <= size_in; bidx_ff <= bidx_in; dbyte_ff <= dbyte_in;
      last_ff <= last_in; alen_ff <= alen_in; aoff_ff <= aoff_in;
      info_ff <= info_in; n_ff <= n_in; coff_ff <= coff_in; clen_ff <= clen_in;
      cnt_ff <= cnt_in;
   end

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while a result is pending");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= MaxSlots) else $error("slot count beyond directory");
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= PAGE_V) else $error("item area top beyond page end");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped while stalled");
endmodule

@@ dv/slotted_page_manager_core_test.sv @@
// Self-checking testbench for the slotted page manager core.
// It holds a page predictor, a request queue, a driver and a checking monitor.
// Depends on spm_pkg and the RTL of slotted_page_manager_core.
`timescale 1ns / 1ps

module slotted_page_manager_core_test
   import spm_pkg::*;
();

   localparam int unsigned PageSize = PageBytesDef;
   localparam int unsigned HeadSize = HeaderBytesDef;
   localparam int unsigned SlotSize = SlotBytesDef;
   localparam int unsigned SlotMax  = MaxSlotsDef;
   localparam logic [2:0] OpSpareA = 3'd6;
   localparam logic [2:0] OpSpareB = 3'd7;

   typedef enum logic [1:0] {PACE_FREE, PACE_SLOW_SEND, PACE_SLOW_TAKE, PACE_BOTH} pace_type;

   typedef struct {
      logic [2:0]  opcode;
      logic [9:0]  slot_number;
      logic [13:0] item_size;
      logic [12:0] byte_index;
      logic [7:0]  data_byte;
      logic        last_byte;
      pace_type    pace;
      bit          drain;
   } page_request_type;

   typedef struct {
      logic [1:0]  status;
      logic [13:0] free_space;
      logic [9:0]  slots_in_use;
      logic        live;
      logic [13:0] item_length;
      logic [7:0]  read_byte;
   } page_answer_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_opcode;
   logic [9:0]  req_slot_number;
   logic [13:0] req_item_size;
   logic [12:0] req_byte_index;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [13:0] rsp_free_space;
   logic [9:0]  rsp_slots_in_use;
   logic        rsp_live;
   logic [13:0] rsp_item_length;
   logic [7:0]  rsp_read_byte;

   page_request_type request_q[$];
   page_answer_type  answer_q[$];
   int unsigned sent_count;
   int unsigned taken_count;
   int unsigned error_count;
   pace_type    take_pace;

   // Predicted page contents, with a flag for every byte known to be written.
   byte unsigned page_mem[PageSize];
   bit           page_known[PageSize];
   byte unsigned spare_mem[PageSize];
   bit           spare_known[PageSize];
   int unsigned  slot_off[SlotMax];
   int unsigned  slot_len[SlotMax];
   int unsigned  slots_used;
   int unsigned  area_top;
   bit           add_open;
   int unsigned  add_done;
   int unsigned  add_state;
   int unsigned  add_index;
   int unsigned  add_total;

   slotted_page_manager_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_slot_number  (req_slot_number),
      .req_item_size    (req_item_size),
      .req_byte_index   (req_byte_index),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_free_space   (rsp_free_space),
      .rsp_slots_in_use (rsp_slots_in_use),
      .rsp_live         (rsp_live),
      .rsp_item_length  (rsp_item_length),
      .rsp_read_byte    (rsp_read_byte)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned page_free();
      int unsigned low;
      low = HeadSize + slots_used * SlotSize;
      return (area_top > low) ? area_top - low : 0;
   endfunction

   function automatic void clear_add();
      add_open  = 1'b0;
      add_done  = 0;
      add_state = ST_OK;
      add_index = 0;
      add_total = 0;
   endfunction

   function automatic void clear_page();
      for (int i = 0; i < PageSize; i++) begin
         page_mem[i]   = 8'd0;
         page_known[i] = 1'b1;
      end
      for (int i = 0; i < SlotMax; i++) begin
         slot_off[i] = 0;
         slot_len[i] = 0;
      end
      slots_used = 0;
      area_top   = PageSize;
   endfunction

   function automatic void compact_page();
      int unsigned top;
      int unsigned n;
      int unsigned off;
      int unsigned len;
      top = PageSize;
      n   = 0;
      for (int i = 0; i < PageSize; i++) begin
         spare_mem[i]   = 8'd0;
         spare_known[i] = 1'b1;
      end
      for (int i = 0; i < slots_used && i < SlotMax; i++) begin
         off = slot_off[i];
         len = slot_len[i];
         if (off != 0) begin
            if (len > top || off > PageSize || len > PageSize - off) len = 0;
            top -= len;
            for (int k = 0; k < len; k++) begin
               spare_mem[top + k]   = page_mem[off + k];
               spare_known[top + k] = page_known[off + k];
            end
            slot_off[n] = top;
            slot_len[n] = len;
            n++;
         end
      end
      for (int i = n; i < SlotMax; i++) begin
         slot_off[i] = 0;
         slot_len[i] = 0;
      end
      for (int i = 0; i < PageSize; i++) begin
         page_mem[i]   = spare_mem[i];
         page_known[i] = spare_known[i];
      end
      slots_used = n;
      area_top   = top;
   endfunction

   function automatic page_answer_type predict_page(page_request_type rq);
      page_answer_type ans;
      int unsigned slot;
      int unsigned size;
      int unsigned idx;
      int unsigned addr;
      int unsigned off;
      bit ok_slot;
      slot = rq.slot_number;
      size = rq.item_size;
      idx  = rq.byte_index;
      ans  = '{ST_OK, 14'd0, 10'd0, 1'b0, 14'd0, 8'd0};
      ok_slot = slot >= 1 && slot <= slots_used && slot <= SlotMax;
      if (rq.opcode != OP_ADD && add_open) clear_add();
      case (rq.opcode)
         OP_INIT: clear_page();
         OP_ADD: begin
            if (!add_open) begin
               add_open  = 1'b1;
               add_done  = 0;
               add_total = size;
               if (slot < 1 || slot > slots_used + 1 || slot > SlotMax) begin
                  add_state = ST_BAD_SLOT;
               end else if (page_free() <= size + SlotSize) begin
                  add_state = ST_NO_SPACE;
               end else begin
                  add_state = ST_OK;
                  add_index = slot - 1;
                  area_top -= size;
                  slot_off[add_index] = area_top;
                  slot_len[add_index] = size;
                  if (slot > slots_used) slots_used++;
               end
            end
            ans.status = 2'(add_state);
            if (add_state == ST_OK) begin
               if (add_done < add_total) begin
                  addr = slot_off[add_index] + add_done;
                  if (addr < PageSize) begin
                     page_mem[addr]   = rq.data_byte;
                     page_known[addr] = 1'b1;
                  end
                  add_done++;
               end
               ans.live        = slot_off[add_index] != 0;
               ans.item_length = 14'(slot_len[add_index]);
            end
            if (rq.last_byte) clear_add();
         end
         OP_DELETE: begin
            if (!ok_slot) begin
               ans.status = ST_BAD_SLOT;
            end else begin
               slot_off[slot - 1] = 0;
               slot_len[slot - 1] = 0;
            end
         end
         OP_COMPACT: compact_page();
         OP_CHECK: begin
            if (!ok_slot) begin
               ans.status = ST_BAD_SLOT;
            end else begin
               ans.live        = slot_off[slot - 1] != 0;
               ans.item_length = 14'(slot_len[slot - 1]);
            end
         end
         OP_READ: begin
            if (!ok_slot) begin
               ans.status = ST_BAD_SLOT;
            end else begin
               off = slot_off[slot - 1];
               ans.item_length = 14'(slot_len[slot - 1]);
               ans.live = off != 0;
               if (off == 0) ans.status = ST_NOT_LIVE;
               else if (idx >= slot_len[slot - 1] || off + idx >= PageSize)
                  ans.status = ST_BAD_SLOT;
               else ans.read_byte = page_mem[off + idx];
            end
         end
         default: ;
      endcase
      ans.free_space   = 14'(page_free());
      ans.slots_in_use = 10'(slots_used);
      return ans;
   endfunction

   // The predictor runs in queue order, which is the order of transfer.
   task automatic queue_request(logic [2:0] op, int unsigned slot, int unsigned size,
                                int unsigned idx, int unsigned data, bit last,
                                pace_type pace, bit drain = 1'b0);
      page_request_type rq;
      rq.opcode      = op;
      rq.slot_number = 10'(slot);
      rq.item_size   = 14'(size);
      rq.byte_index  = 13'(idx);
      rq.data_byte   = 8'(data);
      rq.last_byte   = last;
      rq.pace        = pace;
      rq.drain       = drain;
      request_q.push_back(rq);
      answer_q.push_back(predict_page(rq));
   endtask

   task automatic queue_add(int unsigned slot, int unsigned size, int unsigned beats,
                            bit finish, pace_type pace);
      for (int b = 0; b < beats; b++)
         queue_request(OP_ADD, slot, size, $urandom, $urandom,
                       finish && b == beats - 1, pace);
   endtask

   // Reads only bytes known to be written; otherwise a liveness check is sent.
   task automatic queue_read(int unsigned slot, int unsigned idx, pace_type pace);
      int unsigned off;
      bit safe;
      safe = 1'b1;
      if (slot >= 1 && slot <= slots_used) begin
         off = slot_off[slot - 1];
         if (off != 0 && idx < slot_len[slot - 1] && off + idx < PageSize)
            safe = page_known[off + idx];
      end
      if (safe) queue_request(OP_READ, slot, $urandom, idx, $urandom, $urandom_range(1), pace);
      else queue_request(OP_CHECK, slot, $urandom, idx, $urandom, $urandom_range(1), pace);
   endtask

   task automatic build_stimulus();
      pace_type pace;
      int unsigned roll;
      int unsigned slot;
      int unsigned size;
      int unsigned beats;
      bit filled;
      filled = 1'b0;
      queue_request(OP_INIT, 0, 0, 0, 0, 0, PACE_FREE);
      queue_request(OP_CHECK, 0, 0, 0, 0, 0, PACE_FREE);
      queue_request(OP_ADD, 1, 3, 0, 8'hff, 0, PACE_FREE);
      queue_request(OP_ADD, 1, 3, 0, 8'h00, 0, PACE_FREE);
      queue_request(OP_ADD, 1, 3, 0, 8'haa, 1, PACE_FREE);
      queue_request(OP_ADD, 2, 0, 0, 8'h11, 1, PACE_FREE);
      queue_request(OP_ADD, 3, 8192, 0, 8'h22, 1, PACE_FREE);
      queue_request(OP_ADD, 5, 1, 0, 8'h33, 1, PACE_FREE);
      queue_read(1, 0, PACE_FREE);
      queue_read(1, 2, PACE_FREE);
      queue_read(1, 4096, PACE_FREE);
      queue_request(OP_CHECK, 2, 0, 0, 0, 0, PACE_FREE);
      queue_request(OP_DELETE, 2, 0, 0, 0, 0, PACE_FREE);
      queue_request(OP_DELETE, 2, 0, 0, 0, 0, PACE_FREE);
      queue_request(OP_READ, 2, 0, 0, 0, 0, PACE_FREE);
      queue_request(OpSpareA, 1, 16383, 8191, 255, 1, PACE_FREE);
      queue_request(OpSpareB, 0, 0, 0, 0, 0, PACE_FREE);
      queue_add(1, 2, 3, 1'b1, PACE_FREE);
      queue_add(3, 4, 2, 1'b0, PACE_FREE);
      queue_request(OP_CHECK, 3, 0, 0, 0, 0, PACE_FREE);
      queue_request(OP_COMPACT, 0, 0, 0, 0, 0, PACE_FREE);
      queue_read(1, 1, PACE_FREE);
      queue_request(OP_DELETE, 9, 0, 0, 0, 0, PACE_FREE);
      queue_request(OP_READ, 512, 0, 8191, 0, 0, PACE_FREE);
      queue_request(OP_INIT, 1023, 16383, 8191, 255, 1, PACE_FREE, 1'b1);
      while (request_q.size() < 1450) begin
         pace = pace_type'((request_q.size() / 150) % 4);
         roll = $urandom_range(999);
         if (!filled && request_q.size() > 600) begin
            // Fill the directory to its last slot with empty items.
            filled = 1'b1;
            queue_request(OP_INIT, 0, 0, 0, 0, 0, pace);
            for (int s = 1; s <= SlotMax; s++) queue_add(s, 0, 1, 1'b1, pace);
            queue_request(OP_CHECK, SlotMax, 0, 0, 0, 0, pace);
            queue_read(SlotMax, 0, pace);
            queue_request(OP_DELETE, SlotMax, 0, 0, 0, 0, pace);
            queue_request(OP_COMPACT, 0, 0, 0, 0, 0, pace, 1'b1);
         end else if (roll < 450) begin
            roll = $urandom_range(99);
            if (roll < 75) slot = slots_used + 1;
            else if (roll < 92) slot = $urandom_range(slots_used + 1, 1);
            else slot = $urandom_range(SlotMax, 0);
            if (slot > SlotMax) slot = SlotMax;
            roll = $urandom_range(99);
            if (roll < 80) size = $urandom_range(24);
            else if (roll < 93) size = $urandom_range(400);
            else if (roll < 97) size = $urandom_range(8192, 2000);
            else size = 8192;
            beats = (size == 0) ? 1 : size;
            if (beats > 48)
               beats = (page_free() <= size + SlotSize || slot > slots_used + 1) ? 6 : 48;
            roll = $urandom_range(99);
            if (roll < 8) queue_add(slot, size, $urandom_range(beats, 1), 1'b0, pace);
            else if (roll < 15) queue_add(slot, size, beats + $urandom_range(3, 1), 1'b1, pace);
            else queue_add(slot, size, beats, 1'b1, pace);
         end else if (roll < 750) begin
            slot = $urandom_range(slots_used + 1, 1);
            if ($urandom_range(9) == 0) slot = $urandom_range(SlotMax);
            if (slot >= 1 && slot <= slots_used && slot_len[slot - 1] != 0
                && $urandom_range(9) != 0)
               queue_read(slot, $urandom_range(slot_len[slot - 1] - 1), pace);
            else queue_read(slot, $urandom_range(8191), pace);
         end else if (roll < 850) begin
            queue_request(OP_CHECK, $urandom_range(slots_used + 1), $urandom, $urandom,
                          $urandom, $urandom_range(1), pace);
         end else if (roll < 940) begin
            queue_request(OP_DELETE, $urandom_range(slots_used + 1), $urandom, $urandom,
                          $urandom, $urandom_range(1), pace);
         end else if (roll < 960) begin
            queue_request($urandom_range(1) ? OpSpareA : OpSpareB, $urandom, $urandom,
                          $urandom, $urandom, $urandom_range(1), pace);
         end else if (roll < 985) begin
            queue_request(OP_COMPACT, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(1), pace, $urandom_range(3) == 0);
         end else begin
            queue_request(OP_INIT, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(1), pace);
         end
      end
   endtask

   function automatic int unsigned send_idle(pace_type pace);
      case (pace)
         PACE_SLOW_SEND: return 84;
         PACE_BOTH:      return 28;
         default:        return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid       <= 1'b0;
         req_opcode      <= OP_INIT;
         req_slot_number <= '0;
         req_item_size   <= '0;
         req_byte_index  <= '0;
         req_data_byte   <= '0;
         req_last_byte   <= 1'b0;
         take_pace       <= PACE_FREE;
         sent_count = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) sent_count++;
         if (request_q.size() != 0
             && !(request_q[0].drain && sent_count != taken_count)
             && $urandom_range(99) >= send_idle(request_q[0].pace)) begin
            req_valid       <= 1'b1;
            req_opcode      <= request_q[0].opcode;
            req_slot_number <= request_q[0].slot_number;
            req_item_size   <= request_q[0].item_size;
            req_byte_index  <= request_q[0].byte_index;
            req_data_byte   <= request_q[0].data_byte;
            req_last_byte   <= request_q[0].last_byte;
            take_pace       <= request_q[0].pace;
            void'(request_q.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      page_answer_type want;
      if (reset) begin
         rsp_stall   <= 1'b0;
         taken_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            taken_count <= taken_count + 1;
            if (answer_q.size() == 0) begin
               error_count++;
               $display("%0t: result transfer with nothing expected", $time);
            end else begin
               want = answer_q.pop_front();
               if (rsp_status !== want.status || rsp_free_space !== want.free_space
                   || rsp_slots_in_use !== want.slots_in_use || rsp_live !== want.live
                   || rsp_item_length !== want.item_length
                   || rsp_read_byte !== want.read_byte) begin
                  error_count++;
                  $display("%0t: expected status %0d free %0d slots %0d live %0d len %0d byte %0d",
                           $time, want.status, want.free_space, want.slots_in_use, want.live,
                           want.item_length, want.read_byte);
                  $display("%0t: actual   status %0d free %0d slots %0d live %0d len %0d byte %0d",
                           $time, rsp_status, rsp_free_space, rsp_slots_in_use, rsp_live,
                           rsp_item_length, rsp_read_byte);
               end
            end
         end
         case (take_pace)
            PACE_SLOW_TAKE: rsp_stall <= $urandom_range(99) < 84;
            PACE_BOTH:      rsp_stall <= $urandom_range(99) < 28;
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   initial begin
      reset = 1'b1;
      clear_page();
      for (int i = 0; i < PageSize; i++) page_known[i] = 1'b0;
      clear_add();
      build_stimulus();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (request_q.size() != 0 || answer_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #40ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
